FILE: sv/slcfr_pkg.sv
package slcfr_pkg;

  localparam int unsigned MaxPayloadBytes = 56;

  localparam logic [7:0]  SyncA   = 8'hA5;
  localparam logic [7:0]  SyncB   = 8'h5A;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  typedef enum logic [2:0] {
    EvPayload = 3'd0,
    EvEmpty   = 3'd1,
    EvCrcErr  = 3'd2,
    EvBadLen  = 3'd3,
    EvOverrun = 3'd4
  } event_e;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] command;
    logic [7:0] sequence_res;
    logic [5:0] payload_length;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       last;
  } result_t;

  typedef enum logic [4:0] {
    StIdle, StLen0, StLen1, StLen2, StLen3,
    StCrcRd, StCrcUp, StGot0, StGot1, StGot2, StCheck,
    StScan0, StScan1, StHdr0, StHdr1, StHdr2,
    StPayRd, StPayOut, StEmit
  } state_e;

  // Fold one byte into a CRC16-CCITT-FALSE remainder, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/slcfr_if.sv
interface slcfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcfr_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] command;
  logic [7:0] sequence_res;
  logic [5:0] payload_length;
  logic [5:0] byte_index;
  logic [7:0] payload_byte;
  logic       last;
  modport source (output valid, output event_res, output command, output sequence_res,
                  output payload_length, output byte_index, output payload_byte,
                  output last, input ready);
  modport sink (input valid, input event_res, input command, input sequence_res,
                input payload_length, input byte_index, input payload_byte,
                input last, output ready);
endinterface

FILE: sv/slcfr_front.sv
module slcfr_front (
  input  logic       clk_i,
  input  logic       rst_ni,
  slcfr_byte_if.sink in_if,
  input  logic       pop_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic [7:0] data_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign valid_o     = (cnt_q != 2'd0);
  assign pop         = pop_i && valid_o;
  assign byte_o      = data_q[rd_ptr_q];

  // Advance queue pointers and count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold the queued bytes
  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= in_if.rx_byte;
    end
  end

endmodule

FILE: sv/slcfr_back.sv
module slcfr_back #(
  parameter int unsigned MAX_PAYLOAD_BYTES = slcfr_pkg::MaxPayloadBytes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  logic [7:0]   q_byte_i,
  output logic         q_pop_o,
  slcfr_res_if.source  out_if
);
  import slcfr_pkg::*;

  localparam int unsigned Cap    = MAX_PAYLOAD_BYTES + 8;
  localparam int unsigned AW     = $clog2(Cap);
  localparam int unsigned FW     = $clog2(Cap + 1);
  localparam logic [FW-1:0] CapF = FW'(Cap);
  localparam logic [16:0] LenMax = 17'(MAX_PAYLOAD_BYTES + 2);

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [15:0]   len_q, len_d;
  logic [15:0]   crc_q, crc_d;
  logic [15:0]   got_q, got_d;
  logic [FW-1:0] off_q, off_d;
  logic [FW-1:0] idx_q, idx_d;
  logic [7:0]    cmd_q, cmd_d;
  logic          chk_q, chk_d;
  result_t       pend_q, pend_d;
  result_t       out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic [7:0]    mem [Cap];
  logic [7:0]    rd_data_q;
  logic          rd_en, wr_en;
  logic [FW-1:0] rd_off, adv_off;
  logic [AW-1:0] rd_addr, wr_addr, adv_addr;

  logic          take, slot_free, len_bad, fits, crc_done, pay_last;
  logic [16:0]   total;
  logic [15:0]   plen;

  // Circular offset from the buffer head
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [FW-1:0] o);
    logic [FW:0] s;
    s = (FW+1)'(h) + (FW+1)'(o);
    if (s >= (FW+1)'(Cap)) begin
      s = s - (FW+1)'(Cap);
    end
    return AW'(s);
  endfunction

  assign take      = (state_q == StIdle) && q_valid_i;
  assign q_pop_o   = take;
  assign slot_free = !out_valid_q || out_if.ready;
  assign total     = {1'b0, len_q} + 17'd6;
  assign plen      = len_q - 16'd2;
  assign len_bad   = (len_q < 16'd2) || ({1'b0, len_q} > LenMax);
  assign fits      = {{(17-FW){1'b0}}, fill_q} >= total;
  assign crc_done  = {{(17-FW){1'b0}}, off_q} == ({1'b0, len_q} + 17'd3);
  assign pay_last  = ({{(17-FW){1'b0}}, idx_q} + 17'd1) == {1'b0, plen};

  // Select the read offset for each fetch state
  always_comb begin
    rd_en  = 1'b1;
    rd_off = '0;
    unique case (state_q)
      StLen0:  rd_off = FW'(2);
      StLen1:  rd_off = FW'(3);
      StCrcRd: rd_off = off_q;
      StGot0:  rd_off = FW'(len_q + 16'd4);
      StGot1:  rd_off = FW'(len_q + 16'd5);
      StScan0: rd_off = '0;
      StHdr0:  rd_off = FW'(4);
      StHdr1:  rd_off = FW'(5);
      StPayRd: rd_off = idx_q + FW'(6);
      default: rd_en = 1'b0;
    endcase
  end

  assign wr_en = take && ((fill_q == '0 && q_byte_i == SyncA) ||
                          (fill_q == FW'(1) && q_byte_i == SyncB) ||
                          (fill_q >= FW'(2) && fill_q < CapF));

  // Amount dropped from the front of the buffer: one byte on a CRC mismatch
  // and during the resync scan, the whole frame otherwise
  always_comb begin
    adv_off = FW'(total);
    if ((state_q == StCheck && got_q != crc_q) || state_q == StScan1) begin
      adv_off = FW'(1);
    end
  end

  assign rd_addr  = wrap(head_q, rd_off);
  assign wr_addr  = wrap(head_q, fill_q);
  assign adv_addr = wrap(head_q, adv_off);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          if (fill_q <= FW'(1)) begin
            state_d = StIdle;
          end else if (fill_q >= CapF) begin
            state_d = StEmit;
          end else if (fill_q == FW'(3) || fill_q >= FW'(7)) begin
            state_d = StLen0;
          end
        end
      end
      StLen0: state_d = StLen1;
      StLen1: state_d = StLen2;
      StLen2: state_d = StLen3;
      StLen3: begin
        if (chk_q) begin
          state_d = len_bad ? StEmit : StIdle;
        end else begin
          state_d = fits ? StCrcRd : StIdle;
        end
      end
      StCrcRd: state_d = StCrcUp;
      StCrcUp: state_d = crc_done ? StGot0 : StCrcRd;
      StGot0:  state_d = StGot1;
      StGot1:  state_d = StGot2;
      StGot2:  state_d = StCheck;
      StCheck: begin
        if (got_q != crc_q) begin
          state_d = StScan0;
        end else if (len_q < 16'd2) begin
          state_d = StEmit;
        end else begin
          state_d = StHdr0;
        end
      end
      StScan0: state_d = (fill_q == '0) ? StEmit : StScan1;
      StScan1: state_d = (rd_data_q == SyncA) ? StEmit : StScan0;
      StHdr0:  state_d = StHdr1;
      StHdr1:  state_d = StHdr2;
      StHdr2:  state_d = (plen == 16'd0) ? StEmit : StPayRd;
      StPayRd: state_d = StPayOut;
      StPayOut: begin
        if (slot_free) begin
          state_d = pay_last ? StIdle : StPayRd;
        end
      end
      StEmit: begin
        if (slot_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath updates and result loading
  always_comb begin
    head_d      = head_q;
    fill_d      = fill_q;
    len_d       = len_q;
    crc_d       = crc_q;
    got_d       = got_q;
    off_d       = off_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    chk_d       = chk_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_if.ready;
    unique case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          chk_d = (fill_q == FW'(3));
          if (fill_q == '0) begin
            if (q_byte_i == SyncA) begin
              fill_d = FW'(1);
            end
          end else if (fill_q == FW'(1)) begin
            if (q_byte_i == SyncB) begin
              fill_d = FW'(2);
            end else if (q_byte_i != SyncA) begin
              fill_d = '0;
            end
          end else if (fill_q >= CapF) begin
            fill_d = '0;
            pend_d = '{event_res: EvOverrun, last: 1'b1, default: '0};
          end else begin
            fill_d = fill_q + FW'(1);
          end
        end
      end
      StLen1: len_d[7:0]  = rd_data_q;
      StLen2: len_d[15:8] = rd_data_q;
      StLen3: begin
        crc_d = CrcInit;
        off_d = FW'(2);
        if (chk_q && len_bad) begin
          fill_d = '0;
          pend_d = '{event_res: EvBadLen, last: 1'b1, default: '0};
        end
      end
      StCrcUp: begin
        crc_d = crc_byte(crc_q, rd_data_q);
        off_d = off_q + FW'(1);
      end
      StGot1: got_d[15:8] = rd_data_q;
      StGot2: got_d[7:0]  = rd_data_q;
      StCheck: begin
        if (got_q != crc_q) begin
          head_d = adv_addr;
          fill_d = fill_q - FW'(1);
          pend_d = '{event_res: EvCrcErr, last: 1'b1, default: '0};
        end else if (len_q < 16'd2) begin
          head_d = adv_addr;
          fill_d = fill_q - adv_off;
          pend_d = '{event_res: EvBadLen, last: 1'b1, default: '0};
        end
      end
      StScan1: begin
        if (rd_data_q != SyncA) begin
          head_d = adv_addr;
          fill_d = fill_q - FW'(1);
        end
      end
      StHdr1: cmd_d = rd_data_q;
      StHdr2: begin
        idx_d = '0;
        if (plen == 16'd0) begin
          head_d = adv_addr;
          fill_d = fill_q - adv_off;
          pend_d = '{event_res: EvEmpty, command: cmd_q, sequence_res: rd_data_q,
                     last: 1'b1, default: '0};
        end else begin
          pend_d = '{event_res: EvPayload, command: cmd_q, sequence_res: rd_data_q,
                     payload_length: plen[5:0], default: '0};
        end
      end
      StPayOut: begin
        if (slot_free) begin
          out_d                = pend_q;
          out_d.byte_index     = idx_q[5:0];
          out_d.payload_byte   = rd_data_q;
          out_d.last           = pay_last;
          out_valid_d          = 1'b1;
          idx_d                = idx_q + FW'(1);
          if (pay_last) begin
            head_d = adv_addr;
            fill_d = fill_q - adv_off;
          end
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    crc_q  <= crc_d;
    got_q  <= got_d;
    off_q  <= off_d;
    idx_q  <= idx_d;
    cmd_q  <= cmd_d;
    chk_q  <= chk_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Frame buffer: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= q_byte_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.event_res      = out_q.event_res;
  assign out_if.command        = out_q.command;
  assign out_if.sequence_res   = out_q.sequence_res;
  assign out_if.payload_length = out_q.payload_length;
  assign out_if.byte_index     = out_q.byte_index;
  assign out_if.payload_byte   = out_q.payload_byte;
  assign out_if.last           = out_q.last;

endmodule

FILE: sv/sof_len_crc_frame_receiver.sv
// Byte-stream deframer for A5 5A / LEN / CMD / SEQ / payload / CRC16 frames.
// in_if carries one received byte per item; out_if carries result items:
// one per payload byte of a frame whose CRC matches, or a single event item
// (empty frame, CRC mismatch, bad length, overrun). last marks the final
// result caused by one input byte.
// A two-entry byte queue sits in front of the parsing engine, so input is
// taken while the engine works or a result waits in the output register.
// Engine steps: a byte that only extends the buffer is stored from the idle
// state, and a length fetch and check reads LEN. Once a frame may be complete,
// the CRC walk over the frame memory reads and folds each byte in turn, then
// the received CRC is fetched and checked, the header is fetched, and each
// payload result is read and emitted. A CRC resync scan drops bytes one by one.
// Reset empties the queue and the frame buffer (fill count to zero); buffer
// contents need no clearing. When the receiver stalls, the current result
// holds in the output register, the engine waits, and once the queue is full
// in_if.ready falls.
module sof_len_crc_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD_BYTES = slcfr_pkg::MaxPayloadBytes
) (
  input logic         clk_i,
  input logic         rst_ni,
  slcfr_byte_if.sink  in_if,
  slcfr_res_if.source out_if
);
  import slcfr_pkg::*;

  logic       q_valid;
  logic       q_pop;
  logic [7:0] q_byte;

  slcfr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .byte_o  (q_byte)
  );

  slcfr_back #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_byte_i  (q_byte),
    .q_pop_o   (q_pop),
    .out_if    (out_if)
  );

endmodule
